>>> rtl/core/lnsw_pkg.sv
// Shared types and constants for the LCD nibble shift register writer.
// Used by lnsw_frame_gen and lcd_nibble_shift_register_writer; no dependencies.
package lnsw_pkg;

    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_CHAR   = 2'd1,
        OP_CURSOR = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam int FRAME_BITS  = 8;
    localparam int FRAME_COUNT = 6;
    localparam int RUN_BITS    = FRAME_COUNT * FRAME_BITS;
    localparam int IDX_W       = $clog2(RUN_BITS);
    localparam int COL_COUNT   = 16;
    localparam int COL_W       = $clog2(COL_COUNT);

    localparam logic [7:0] EN_BIT     = 8'h08;
    localparam logic [7:0] EN_RS_BITS = 8'h0C;
    localparam logic [7:0] RS_BIT     = 8'h04;
    localparam logic [7:0] HI_NIBBLE  = 8'hF0;
    localparam logic [7:0] ROW1_BASE  = 8'h80;
    localparam logic [7:0] ROW2_BASE  = 8'hC0;

    typedef logic [RUN_BITS-1:0] t_run;
    typedef logic [IDX_W-1:0]    t_idx;

endpackage

>>> rtl/core/lnsw_frame_gen.sv
// Builds the six latch frames for one LCD request as one 48-bit word, first frame
// in the top byte. Depends on lnsw_pkg.
module lnsw_frame_gen (
    input  lnsw_pkg::t_op  i_op,
    input  logic [7:0]     i_data,
    input  logic [1:0]     i_row,
    input  logic [4:0]     i_col,
    output lnsw_pkg::t_run o_frames
);
    import lnsw_pkg::*;

    logic [7:0]       byte_val;
    logic             rs;
    logic [7:0]       ctl;
    logic [7:0]       keep;
    logic [7:0]       hi;
    logic [7:0]       lo;
    logic [COL_W-1:0] col_off;
    logic [7:0]       row_base;

    // Columns count from one; the offset wraps within the row width.
    assign col_off  = i_col[COL_W-1:0] - COL_W'(1);
    assign row_base = (i_row == 2'd1) ? ROW1_BASE : ROW2_BASE;

    always_comb begin
        case (i_op)
            OP_CMD: begin
                byte_val = i_data;
                rs       = 1'b0;
            end
            OP_CHAR: begin
                byte_val = i_data;
                rs       = 1'b1;
            end
            OP_CURSOR: begin
                byte_val = row_base | 8'(col_off);
                rs       = 1'b0;
            end
            default: begin
                byte_val = i_data;
                rs       = 1'b0;
            end
        endcase
    end

    assign ctl  = rs ? EN_RS_BITS : EN_BIT;
    assign keep = rs ? RS_BIT : 8'h00;
    assign hi   = byte_val & HI_NIBBLE;
    assign lo   = {byte_val[3:0], 4'h0};

    assign o_frames = {ctl, hi | ctl, hi | keep, ctl, lo | ctl, lo | keep};

endmodule

>>> rtl/core/lcd_nibble_shift_register_writer.sv
// Each accepted item (command, character or cursor move) is sent to a 4-bit-mode
// character LCD as six 8-bit latch frames, shifted out MSB first: one output item
// per bit, 48 per input item, at one bit per cycle while the sink is ready. One
// further request is held in the input register, so consecutive runs follow without a
// gap. Operation code 3 is accepted and produces no output. Depends on lnsw_pkg and
// lnsw_frame_gen.
module lcd_nibble_shift_register_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], row[9:8], column[14:10], zeros
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // serial_bit[0], zeros
    output logic        m_axis_tuser,   // latch_after[0]
    output logic        m_axis_tlast
);
    import lnsw_pkg::*;

    // Pending request.
    logic       r_in_valid, n_in_valid;
    t_op        r_in_op;
    logic [7:0] r_in_data;
    logic [1:0] r_in_row;
    logic [4:0] r_in_col;

    // Serializer.
    logic r_busy, n_busy;
    t_idx r_idx, n_idx;
    t_run r_sh;
    t_run frames;

    logic in_fire;
    logic out_fire;
    logic run_end;
    logic slot_free;
    logic load;

    lnsw_frame_gen u_frame_gen (
        .i_op     (r_in_op),
        .i_data   (r_in_data),
        .i_row    (r_in_row),
        .i_col    (r_in_col),
        .o_frames (frames)
    );

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = r_busy && m_axis_tready;
    assign run_end   = (r_idx == IDX_W'(RUN_BITS - 1));
    assign slot_free = !r_busy || (out_fire && run_end);
    assign load      = r_in_valid && slot_free;

    assign s_axis_tready = !r_in_valid || load;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            // An unused operation is taken and dropped here.
            n_in_valid = (t_op'(s_axis_tuser) != OP_NONE);
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (out_fire) begin
            if (run_end) begin
                n_busy = 1'b0;
            end
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_busy     <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_busy     <= n_busy;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_data <= s_axis_tdata[7:0];
            r_in_row  <= s_axis_tdata[9:8];
            r_in_col  <= s_axis_tdata[14:10];
        end
        if (load) begin
            r_sh <= frames;
        end else if (out_fire) begin
            r_sh <= {r_sh[RUN_BITS-2:0], 1'b0};
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {7'b0, r_sh[RUN_BITS-1]};
    assign m_axis_tuser  = (r_idx[2:0] == 3'(FRAME_BITS - 1));
    assign m_axis_tlast  = run_end;

`ifndef NO_ASSERTIONS
    a_last_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("final bit of a run does not pulse the latch");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !run_end) |=> (r_busy && r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("serializer stopped or skipped a bit inside a run");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_fire) |=> (r_busy && $stable(r_idx) && $stable(r_sh)))
        else $error("serializer state changed while the output was stalled");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !slot_free) |=> r_in_valid)
        else $error("pending request lost while the serializer was busy");
`endif

endmodule
